// File: sv/spq_pkg.sv
// spq_pkg: types and constants of the sorted priority queue
// used by spq_cell and sorted_priority_queue, depends on nothing
package spq_pkg;

  localparam int KEY_BITS     = 40;
  localparam int PAYLOAD_BITS = 32;
  localparam int OCC_BITS     = 5;
  localparam int QUEUE_DEPTH  = 16;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    op_t                     operation;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } in_item_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]     out_key;
    logic [PAYLOAD_BITS-1:0] out_payload;
    status_t                 status;
    logic [OCC_BITS-1:0]     occupancy;
  } out_item_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t entry;
  } cmd_t;

endpackage

// File: sv/sorted_priority_queue.sv
// sorted_priority_queue: bounded priority queue as a chain of compare-and-shift cells
// all cells compare and shift in parallel; results are registered at the output
// throughput: one insert or remove per cycle while the output is not stalled
// reset: clears the occupancy counter, the cell valid bits and the output valid
// depends on spq_pkg and spq_cell
module sorted_priority_queue #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  spq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output spq_pkg::out_item_t out_data
);

  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_BITS-1:0] count_r;
  logic [CNT_BITS-1:0] count_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  spq_pkg::out_item_t  out_data_r;
  spq_pkg::out_item_t  out_data_nxt;

  logic                in_fire;
  logic                is_full;
  logic                is_empty;
  spq_pkg::cmd_t       cmd;

  logic [QUEUE_DEPTH-1:0] cell_valid;
  logic [QUEUE_DEPTH-1:0] cell_keep;
  spq_pkg::entry_t        cell_entry [QUEUE_DEPTH];

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign is_full   = (count_r == CNT_BITS'(QUEUE_DEPTH));
  assign is_empty  = (count_r == '0);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cmd.ins           = in_fire && (in_data.operation == spq_pkg::OP_INSERT) && !is_full;
  assign cmd.rem           = in_fire && (in_data.operation == spq_pkg::OP_REMOVE) && !is_empty;
  assign cmd.entry.key     = in_data.key;
  assign cmd.entry.payload = in_data.payload;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic            lk;
    logic            lv;
    spq_pkg::entry_t le;
    logic            rv;
    spq_pkg::entry_t re;

    if (i == 0) begin : g_head
      assign lk = 1'b1;
      assign lv = 1'b1;
      assign le = cmd.entry;
    end else begin : g_body
      assign lk = cell_keep[i-1];
      assign lv = cell_valid[i-1];
      assign le = cell_entry[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign rv = 1'b0;
      assign re = cell_entry[i];
    end else begin : g_mid
      assign rv = cell_valid[i+1];
      assign re = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .left_keep   (lk),
      .left_valid  (lv),
      .left_entry  (le),
      .right_valid (rv),
      .right_entry (re),
      .valid       (cell_valid[i]),
      .entry       (cell_entry[i]),
      .keep        (cell_keep[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CNT_BITS'(1);
    end else if (cmd.rem) begin
      count_nxt = count_r - CNT_BITS'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_data_nxt             = out_data_r;
    if (in_fire) begin
      out_data_nxt.out_key     = '0;
      out_data_nxt.out_payload = '0;
      out_data_nxt.status      = spq_pkg::ST_DONE;
      out_data_nxt.occupancy   = spq_pkg::OCC_BITS'(count_nxt);
      case (in_data.operation)
        spq_pkg::OP_INSERT: begin
          if (is_full) begin
            out_data_nxt.status = spq_pkg::ST_FULL;
          end
        end
        spq_pkg::OP_REMOVE: begin
          if (is_empty) begin
            out_data_nxt.status = spq_pkg::ST_EMPTY;
          end else begin
            out_data_nxt.out_key     = cell_entry[0].key;
            out_data_nxt.out_payload = cell_entry[0].payload;
          end
        end
        default: begin
          out_data_nxt.status = spq_pkg::ST_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(QUEUE_DEPTH))
    else $error("occupancy above queue depth");

  a_valid_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(count_r))
    else $error("cell valid bits disagree with occupancy");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.operation == spq_pkg::OP_REMOVE && is_empty)
      |=> (out_data_r.status == spq_pkg::ST_EMPTY))
    else $error("remove on empty queue not flagged");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.operation == spq_pkg::OP_INSERT && is_full)
      |=> (out_data_r.status == spq_pkg::ST_FULL && count_r == CNT_BITS'(QUEUE_DEPTH)))
    else $error("insert on full queue not dropped");

endmodule

// File: sv/spq_cell.sv
// spq_cell: one slot of the shift-register queue with its own compare
// depends on spq_pkg
module spq_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  spq_pkg::cmd_t   cmd,
  input  logic            left_keep,
  input  logic            left_valid,
  input  spq_pkg::entry_t left_entry,
  input  logic            right_valid,
  input  spq_pkg::entry_t right_entry,
  output logic            valid,
  output spq_pkg::entry_t entry,
  output logic            keep
);

  logic            valid_r;
  logic            valid_nxt;
  spq_pkg::entry_t entry_r;
  spq_pkg::entry_t entry_nxt;

  // slot stays put on insert when it holds a key not above the new one
  assign keep  = valid_r && (entry_r.key <= cmd.entry.key);
  assign valid = valid_r;
  assign entry = entry_r;

  always_comb begin
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    if (cmd.ins) begin
      valid_nxt = valid_r | left_valid;
      if (!keep) begin
        if (left_keep) begin
          entry_nxt = cmd.entry;
        end else begin
          entry_nxt = left_entry;
        end
      end
    end else if (cmd.rem) begin
      valid_nxt = right_valid;
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// File: verif/testbench.sv
// testbench for sorted_priority_queue: inserts and removes keyed entries and checks every
// result against a sorted mirror of the queue held in a small scoreboard class
// depends on spq_pkg and sorted_priority_queue
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 450;
  localparam int LONG_HOLD    = 90;

  class pq_scoreboard;
    spq_pkg::entry_t    stored_entries[$];
    spq_pkg::out_item_t pending_results[$];
    int                 errors;

    function void note_request(spq_pkg::in_item_t it);
      spq_pkg::out_item_t r;
      spq_pkg::entry_t    e;
      int                 pos;
      r = '0;
      r.status = spq_pkg::ST_DONE;
      if (it.operation == spq_pkg::OP_INSERT) begin
        if (stored_entries.size() >= spq_pkg::QUEUE_DEPTH) begin
          r.status = spq_pkg::ST_FULL;
        end else begin
          pos = 0;
          while (pos < stored_entries.size() && stored_entries[pos].key <= it.key) pos++;
          e.key = it.key;
          e.payload = it.payload;
          stored_entries.insert(pos, e);
        end
      end else if (stored_entries.size() == 0) begin
        r.status = spq_pkg::ST_EMPTY;
      end else begin
        e = stored_entries.pop_front();
        r.out_key = e.key;
        r.out_payload = e.payload;
      end
      r.occupancy = spq_pkg::OCC_BITS'(stored_entries.size());
      pending_results.push_back(r);
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %h got %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(spq_pkg::out_item_t got);
      spq_pkg::out_item_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with no item waiting, got %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("out_key", want.out_key, got.out_key);
        check_field("out_payload", want.out_payload, got.out_payload);
        check_field("status", want.status, got.status);
        check_field("occupancy", want.occupancy, got.occupancy);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  spq_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  spq_pkg::out_item_t out_data;

  pq_scoreboard board = new();
  bit hold_off = 1'b0;
  int burst_left = 0;

  sorted_priority_queue dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int next_gap();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      return $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    return 0;
  endfunction

  task automatic send_item(input spq_pkg::in_item_t it, input int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    board.note_request(it);
  endtask

  function automatic spq_pkg::in_item_t make_item(spq_pkg::op_t op,
                                                  logic [spq_pkg::KEY_BITS-1:0] key,
                                                  logic [spq_pkg::PAYLOAD_BITS-1:0] payload);
    spq_pkg::in_item_t it;
    it.operation = op;
    it.key = key;
    it.payload = payload;
    return it;
  endfunction

  function automatic spq_pkg::in_item_t random_item(int insert_pct);
    logic [spq_pkg::KEY_BITS-1:0] key;
    case ($urandom_range(0, 3))
      0: key = spq_pkg::KEY_BITS'({$urandom, $urandom});
      1: key = spq_pkg::KEY_BITS'($urandom_range(0, 7));
      2: begin
        for (int c = 0; c < spq_pkg::KEY_BITS / 8; c++) begin
          key[c*8 +: 8] = 8'h30 + 8'($urandom_range(0, 9));
        end
      end
      default: key = $urandom_range(0, 1) ? '1 : spq_pkg::KEY_BITS'({$urandom, $urandom});
    endcase
    return make_item($urandom_range(1, 100) <= insert_pct ? spq_pkg::OP_INSERT
                                                          : spq_pkg::OP_REMOVE,
                     key, $urandom);
  endfunction

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int rx_cycle;
    rx_cycle = 0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_off = 1'b0;
        out_ready <= 1'b1;
      end else begin
        case ((rx_cycle / 64) % 4)
          0: out_ready <= 1'b1;
          1: out_ready <= (rx_cycle % 4) != 3;
          2: out_ready <= $urandom_range(0, 1);
          default: out_ready <= $urandom_range(0, 4) == 0;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_data);
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) idle = 0;
      else idle++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int sent;
    int phase_len;
    int insert_pct;
    bit pressure_done;
    sent = 0;
    pressure_done = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty remove, key extremes, equal keys in arrival order
    send_item(make_item(spq_pkg::OP_REMOVE, '0, '0), 0);
    send_item(make_item(spq_pkg::OP_INSERT, '1, '1), 0);
    send_item(make_item(spq_pkg::OP_INSERT, '0, '0), 0);
    send_item(make_item(spq_pkg::OP_INSERT, 40'd5, 32'h0000_00a1), 0);
    send_item(make_item(spq_pkg::OP_INSERT, 40'd5, 32'h0000_00a2), 0);
    send_item(make_item(spq_pkg::OP_INSERT, 40'd5, 32'h0000_00a3), 0);
    send_item(make_item(spq_pkg::OP_INSERT, 40'h41_42_31_32_33, 32'hdead_beef), 0);
    send_item(make_item(spq_pkg::OP_INSERT, 40'h41_41_39_39_39, 32'h1234_5678), 0);
    repeat (8) send_item(make_item(spq_pkg::OP_REMOVE, '1, '1), 0);
    send_item(make_item(spq_pkg::OP_REMOVE, '0, '0), 0);

    // random phases that fill, drain or mix the queue
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(15, 40);
      case ($urandom_range(0, 2))
        0: insert_pct = 85;
        1: insert_pct = 20;
        default: insert_pct = 50;
      endcase
      if (!pressure_done && sent > 150) begin
        pressure_done = 1'b1;
        hold_off = 1'b1;
        repeat (30) send_item(random_item(70), 0);
        sent += 30;
      end
      repeat (phase_len) send_item(random_item(insert_pct), next_gap());
      sent += phase_len;
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (board.errors == 0 && board.pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
